// File: hw/rtl/msd_pkg.sv
// Shared types and constants for the mean / sample standard deviation block.
// Holds the request and response payloads, the shared ALU bundles and the
// sequencer state type. No dependencies.
package msd_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int WORD_W      = 64;
   localparam int STEP_W      = 6;
   localparam int DIV_STEPS   = 64;
   localparam int MUL_STEPS   = 64;
   localparam int SQRT_STEPS  = 32;
   localparam int COUNT_OUT_W = 17;
   localparam int RESULT_W    = 16;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          last;
   } req_type;

   typedef struct packed {
      logic signed [RESULT_W-1:0] mean;
      logic [RESULT_W-1:0]        stdev;
      logic                       stdev_valid;
      logic [COUNT_OUT_W-1:0]     sample_count;
      logic                       overflow;
   } rsp_type;

   typedef struct packed {
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
      logic              sub;
   } alu_op_type;

   typedef struct packed {
      logic [WORD_W-1:0] sum;
      logic              carry;
   } alu_res_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MEAN_DIV,
      ST_NS2_MUL,
      ST_SQ_MUL,
      ST_NUM_SUB,
      ST_DEN_MUL,
      ST_VAR_DIV,
      ST_SQRT,
      ST_DONE
   } state_type;

endpackage

// File: hw/rtl/msd_accum.sv
// Per-set accumulators: sample count, sum, sum of squares and drop flag.
// Depends on msd_pkg.
module msd_accum import msd_pkg::*; #(
   parameter int MAX_SAMPLES = 65536,
   parameter int CNT_W       = 17,
   parameter int SUM_W       = 33,
   parameter int SQ_W        = 47
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  logic                          clear,
   output logic [CNT_W-1:0]              count,
   output logic signed [SUM_W-1:0]       sum,
   output logic [SQ_W-1:0]               square_sum,
   output logic                          dropped
);

   logic [CNT_W-1:0]          count_ff, count_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic [SQ_W-1:0]           sq_ff, sq_in;
   logic                      drop_ff, drop_in;
   logic signed [2*SAMPLE_BITS-1:0] square;
   logic                      full;

   assign square = sample * sample;
   assign full   = (count_ff == CNT_W'(MAX_SAMPLES));

   always_comb begin
      count_in = count_ff;
      sum_in   = sum_ff;
      sq_in    = sq_ff;
      drop_in  = drop_ff;
      if (clear) begin
         count_in = '0;
         sum_in   = '0;
         sq_in    = '0;
         drop_in  = 1'b0;
      end else if (accept) begin
         if (full) begin
            drop_in = 1'b1;
         end else begin
            count_in = count_ff + CNT_W'(1);
            sum_in   = sum_ff + SUM_W'(sample);
            sq_in    = sq_ff + SQ_W'(square);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_ff   <= '0;
         sq_ff    <= '0;
         drop_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         sum_ff   <= sum_in;
         sq_ff    <= sq_in;
         drop_ff  <= drop_in;
      end
   end

   assign count      = count_ff;
   assign sum        = sum_ff;
   assign square_sum = sq_ff;
   assign dropped    = drop_ff;

endmodule

// File: hw/rtl/msd_alu.sv
// Shared 64-bit adder/subtractor used by every arithmetic step of the sequencer.
// Depends on msd_pkg. Carry out on subtract means a >= b.
module msd_alu import msd_pkg::*; (
   input  alu_op_type  op,
   output alu_res_type res
);

   logic [WORD_W:0] full_sum;

   assign full_sum  = {1'b0, op.a} + {1'b0, (op.sub ? ~op.b : op.b)}
                      + {{WORD_W{1'b0}}, op.sub};
   assign res.sum   = full_sum[WORD_W-1:0];
   assign res.carry = full_sum[WORD_W];

endmodule

// File: hw/rtl/msd_seq.sv
// Result sequencer: mean divide, shift-add multiplies, variance divide and
// square root, all on one shared adder. Depends on msd_pkg and msd_alu.
module msd_seq import msd_pkg::*; #(
   parameter int CNT_W = 17,
   parameter int SUM_W = 33,
   parameter int SQ_W  = 47
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    go,
   input  logic [CNT_W-1:0]        count,
   input  logic signed [SUM_W-1:0] sum,
   input  logic [SQ_W-1:0]         square_sum,
   input  logic                    dropped,
   output logic                    busy,
   output logic                    clear,
   output logic                    rsp_valid,
   output rsp_type                 rsp_data
);

   state_type           state_ff, state_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [WORD_W-1:0]   rem_ff, rem_in;     // remainder / product
   logic [WORD_W-1:0]   quo_ff, quo_in;     // dividend, quotient, radicand
   logic [WORD_W-1:0]   d_ff, d_in;         // divisor
   logic [WORD_W-1:0]   mc_ff, mc_in;       // multiplicand, sqrt root
   logic [WORD_W-1:0]   mp_ff, mp_in;       // multiplier
   logic [WORD_W-1:0]   x_ff, x_in;         // n*S2, then numerator
   logic [WORD_W-1:0]   mag_ff, mag_in;
   logic                neg_ff, neg_in;
   logic [RESULT_W-1:0] mean_ff, mean_in;
   logic [RESULT_W-1:0] stdev_ff, stdev_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   alu_op_type          alu_op;
   alu_res_type         alu_res;

   logic [SUM_W-1:0]    mag_w;
   logic [WORD_W-1:0]   div_sh, sqrt_sh, sqrt_trial;
   logic [WORD_W-1:0]   rem_step, quo_step, prod_step, root_step;
   logic                div_last, mul_last, sqrt_last, enough;

   msd_alu u_alu (
      .op  (alu_op),
      .res (alu_res)
   );

   assign mag_w      = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
   assign div_sh     = {rem_ff[WORD_W-2:0], quo_ff[WORD_W-1]};
   assign sqrt_sh    = {rem_ff[WORD_W-3:0], quo_ff[WORD_W-1:WORD_W-2]};
   assign sqrt_trial = {mc_ff[WORD_W-3:0], 2'b01};
   assign div_last   = (step_ff == STEP_W'(DIV_STEPS - 1));
   assign mul_last   = (step_ff == STEP_W'(MUL_STEPS - 1));
   assign sqrt_last  = (step_ff == STEP_W'(SQRT_STEPS - 1));
   assign enough     = (count >= CNT_W'(2));

   // one restoring step for divide and sqrt, one shift-add step for multiply
   assign rem_step  = alu_res.carry ? alu_res.sum : ((state_ff == ST_SQRT) ? sqrt_sh : div_sh);
   assign quo_step  = {quo_ff[WORD_W-2:0], alu_res.carry};
   assign root_step = {mc_ff[WORD_W-2:0], alu_res.carry};
   assign prod_step = mp_ff[0] ? alu_res.sum : rem_ff;

   always_comb begin
      alu_op = '0;
      unique case (state_ff)
         ST_MEAN_DIV, ST_VAR_DIV: begin
            alu_op.a   = div_sh;
            alu_op.b   = d_ff;
            alu_op.sub = 1'b1;
         end
         ST_NS2_MUL, ST_SQ_MUL, ST_DEN_MUL: begin
            alu_op.a   = rem_ff;
            alu_op.b   = mc_ff;
            alu_op.sub = 1'b0;
         end
         ST_NUM_SUB: begin
            alu_op.a   = x_ff;
            alu_op.b   = rem_ff;
            alu_op.sub = 1'b1;
         end
         ST_SQRT: begin
            alu_op.a   = sqrt_sh;
            alu_op.b   = sqrt_trial;
            alu_op.sub = 1'b1;
         end
         default: alu_op = '0;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff + STEP_W'(1);
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      d_in         = d_ff;
      mc_in        = mc_ff;
      mp_in        = mp_ff;
      x_in         = x_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      mean_in      = mean_ff;
      stdev_in     = stdev_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      clear        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            step_in = '0;
            if (go) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            step_in  = '0;
            mag_in   = WORD_W'(mag_w);
            neg_in   = sum[SUM_W-1];
            quo_in   = WORD_W'(mag_w);
            rem_in   = '0;
            d_in     = WORD_W'(count);
            state_in = ST_MEAN_DIV;
         end
         ST_MEAN_DIV: begin
            rem_in = rem_step;
            quo_in = quo_step;
            if (div_last) begin
               step_in = '0;
               mean_in = neg_ff ? RESULT_W'(~quo_step[RESULT_W-1:0] + RESULT_W'(1))
                                : quo_step[RESULT_W-1:0];
               if (enough) begin
                  rem_in   = '0;
                  mc_in    = WORD_W'(square_sum);
                  mp_in    = WORD_W'(count);
                  state_in = ST_NS2_MUL;
               end else begin
                  stdev_in = '0;
                  state_in = ST_DONE;
               end
            end
         end
         ST_NS2_MUL: begin
            rem_in = prod_step;
            mc_in  = {mc_ff[WORD_W-2:0], 1'b0};
            mp_in  = {1'b0, mp_ff[WORD_W-1:1]};
            if (mul_last) begin
               step_in  = '0;
               x_in     = prod_step;
               rem_in   = '0;
               mc_in    = mag_ff;
               mp_in    = mag_ff;
               state_in = ST_SQ_MUL;
            end
         end
         ST_SQ_MUL: begin
            rem_in = prod_step;
            mc_in  = {mc_ff[WORD_W-2:0], 1'b0};
            mp_in  = {1'b0, mp_ff[WORD_W-1:1]};
            if (mul_last) begin
               step_in  = '0;
               state_in = ST_NUM_SUB;
            end
         end
         ST_NUM_SUB: begin
            // a wrapped negative numerator counts as zero
            x_in     = alu_res.carry ? alu_res.sum : '0;
            rem_in   = '0;
            mc_in    = WORD_W'(count);
            mp_in    = WORD_W'(count - CNT_W'(1));
            step_in  = '0;
            state_in = ST_DEN_MUL;
         end
         ST_DEN_MUL: begin
            rem_in = prod_step;
            mc_in  = {mc_ff[WORD_W-2:0], 1'b0};
            mp_in  = {1'b0, mp_ff[WORD_W-1:1]};
            if (mul_last) begin
               step_in  = '0;
               d_in     = prod_step;
               quo_in   = x_ff;
               rem_in   = '0;
               state_in = ST_VAR_DIV;
            end
         end
         ST_VAR_DIV: begin
            rem_in = rem_step;
            quo_in = quo_step;
            if (div_last) begin
               step_in  = '0;
               rem_in   = '0;
               mc_in    = '0;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            rem_in = rem_step;
            quo_in = {quo_ff[WORD_W-3:0], 2'b00};
            mc_in  = root_step;
            if (sqrt_last) begin
               step_in  = '0;
               stdev_in = (|root_step[WORD_W-1:RESULT_W]) ? '1 : root_step[RESULT_W-1:0];
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            step_in             = '0;
            rsp_valid_in        = 1'b1;
            rsp_in.mean         = mean_ff;
            rsp_in.stdev        = stdev_ff;
            rsp_in.stdev_valid  = enough;
            rsp_in.sample_count = COUNT_OUT_W'(count);
            rsp_in.overflow     = dropped;
            clear               = 1'b1;
            state_in            = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      d_ff     <= d_in;
      mc_ff    <= mc_in;
      mp_ff    <= mp_in;
      x_ff     <= x_in;
      mag_ff   <= mag_in;
      neg_ff   <= neg_in;
      mean_ff  <= mean_in;
      stdev_ff <= stdev_in;
      rsp_ff   <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: hw/rtl/mean_and_sample_stdev.sv
// Top level: running mean and sample standard deviation of signed Q8.8 data.
// Depends on msd_pkg, msd_accum, msd_seq (which uses msd_alu).
//
//   channel   ports                        direction  flow
//   request   start, busy, req_data        in         taken when start && !busy
//   response  rsp_valid, rsp_data          out        one-cycle strobe, no stall
//
// A sample without last is summed in the cycle it is taken; busy stays low.
// A sample with last is summed, then the sequencer runs on one 64-bit adder:
// load, mean divide, three shift-add multiplies, subtract, variance divide,
// square root and output, busy high all along; a set of one sample skips
// from the mean divide to output. The response strobes the cycle after output;
// accumulators clear on the same edge. Reset returns to idle with empty sums.
module mean_and_sample_stdev import msd_pkg::*; #(
   parameter int MAX_SAMPLES = 65536
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_W = CNT_W + SAMPLE_BITS;
   localparam int SQ_W  = CNT_W + 2 * SAMPLE_BITS - 2;

   logic                    accept;
   logic                    clear;
   logic [CNT_W-1:0]        count;
   logic signed [SUM_W-1:0] sum;
   logic [SQ_W-1:0]         square_sum;
   logic                    dropped;

   assign accept = start && !busy;

   msd_accum #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .CNT_W       (CNT_W),
      .SUM_W       (SUM_W),
      .SQ_W        (SQ_W)
   ) u_accum (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .sample     (req_data.sample),
      .clear      (clear),
      .count      (count),
      .sum        (sum),
      .square_sum (square_sum),
      .dropped    (dropped)
   );

   msd_seq #(
      .CNT_W (CNT_W),
      .SUM_W (SUM_W),
      .SQ_W  (SQ_W)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .go         (accept && req_data.last),
      .count      (count),
      .sum        (sum),
      .square_sum (square_sum),
      .dropped    (dropped),
      .busy       (busy),
      .clear      (clear),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

endmodule
